>>> hdl/rns_pkg.sv
`default_nettype none

package rns_pkg;

    localparam int TIMER_BITS  = 32;
    localparam int DEBOUNCE_W  = 20;
    localparam int PERIOD_W    = 32;
    localparam int ELAPSED_W   = 16;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 1;
    localparam int CMP_W       = (TIMER_BITS > PERIOD_W) ? TIMER_BITS : PERIOD_W;

    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD   = 1'd1;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 20'd100000;
    localparam logic [PERIOD_W-1:0]   PERIOD_RESET   = 32'd120000000;

    typedef logic [1:0] cycle3_t;

    typedef struct packed {
        logic    led;
        cycle3_t step;
    } rot_state_t;

    function automatic cycle3_t next_of_three(input cycle3_t v);
        cycle3_t r;
        if (v == 2'd0 || v == 2'd3)
        begin
            r = 2'd1;
        end
        else
        begin
            r = v + 2'd1;
        end
        return r;
    endfunction

    function automatic logic [TIMER_BITS-1:0] sat_add(
        input logic [TIMER_BITS-1:0] a,
        input logic [ELAPSED_W-1:0]  b
    );
        logic [TIMER_BITS:0] s;
        s = {1'b0, a} + (TIMER_BITS+1)'(b);
        return s[TIMER_BITS] ? {TIMER_BITS{1'b1}} : s[TIMER_BITS-1:0];
    endfunction

    // active-low mask: first count nozzles cleared, rotated to start at step
    function automatic logic [2:0] off_mask(input cycle3_t step, input cycle3_t count);
        logic [2:0] base;
        logic [2:0] r;
        case (count)
            2'd1:    base = 3'b110;
            2'd2:    base = 3'b100;
            2'd3:    base = 3'b000;
            default: base = 3'b111;
        endcase
        case (step)
            2'd2:    r = {base[1:0], base[2]};
            2'd3:    r = {base[0], base[2:1]};
            default: r = base;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/rns_debounce.sv
`default_nettype none

module rns_debounce (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step_en,
    input  wire logic                          button_level,
    input  wire logic [rns_pkg::ELAPSED_W-1:0] elapsed_us,
    input  wire logic [rns_pkg::DEBOUNCE_W-1:0] debounce_us,
    output rns_pkg::cycle3_t                   count_next
);
    import rns_pkg::*;

    logic                  stable_reg;
    logic                  stable_next;
    logic [TIMER_BITS-1:0] timer_reg;
    logic [TIMER_BITS-1:0] timer_next;
    cycle3_t               count_reg;

    always_comb
    begin
        if (button_level != stable_reg)
        begin
            timer_next = sat_add(timer_reg, elapsed_us);
        end
        else
        begin
            timer_next = '0;
        end
        stable_next = (timer_next >= TIMER_BITS'(debounce_us)) ? button_level : stable_reg;
        // falling edge of the stable level
        count_next = (stable_reg && !stable_next) ? next_of_three(count_reg) : count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg <= 1'b0;
            timer_reg  <= '0;
            count_reg  <= 2'd1;
        end
        else if (step_en)
        begin
            stable_reg <= stable_next;
            timer_reg  <= timer_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/rns_rotator.sv
`default_nettype none

module rns_rotator (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step_en,
    input  wire logic [rns_pkg::ELAPSED_W-1:0] elapsed_us,
    input  wire logic [rns_pkg::PERIOD_W-1:0]  period_us,
    output rns_pkg::rot_state_t                rot_next
);
    import rns_pkg::*;

    logic [TIMER_BITS-1:0] timer_reg;
    logic [TIMER_BITS-1:0] timer_next;
    rot_state_t            rot_reg;

    always_comb
    begin
        if (CMP_W'(timer_reg) < CMP_W'(period_us))
        begin
            timer_next = sat_add(timer_reg, elapsed_us);
            rot_next   = rot_reg;
        end
        else
        begin
            timer_next    = '0;
            rot_next.led  = !rot_reg.led;
            rot_next.step = next_of_three(rot_reg.step);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg    <= '0;
            rot_reg.led  <= 1'b1;
            rot_reg.step <= 2'd1;
        end
        else if (step_en)
        begin
            timer_reg <= timer_next;
            rot_reg   <= rot_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/rotating_nozzle_sequencer_unit.sv
`default_nettype none
// path: input accept into the input register, then the result register (held on stall)
// throughput: one item per cycle unless the output stalls (out_valid high, out_ready low)
// in_ready follows out_ready combinationally through step_en, so the sides are not decoupled
// reset: async active low; stable level 0, nozzle count 1, step 1, led on,
// timers cleared, debounce_us 100000, period_us 120000000

module rotating_nozzle_sequencer_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [rns_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [rns_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            button_level,
    input  wire logic [rns_pkg::ELAPSED_W-1:0]   elapsed_us,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 led_level,
    output logic [2:0]                           nozzle_off_mask,
    output logic [1:0]                           active_nozzles,
    output logic [1:0]                           current_step
);
    import rns_pkg::*;

    logic [DEBOUNCE_W-1:0] debounce_us_reg;
    logic [PERIOD_W-1:0]   period_us_reg;

    logic                 in_valid_reg;
    logic                 button_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;

    logic       out_valid_reg;
    logic       led_reg;
    logic [2:0] mask_reg;
    cycle3_t    count_reg;
    cycle3_t    step_reg;

    logic       step_en;
    cycle3_t    count_next;
    rot_state_t rot_next;

    assign step_en  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_us_reg <= DEBOUNCE_RESET;
            period_us_reg   <= PERIOD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE: debounce_us_reg <= cfg_data[DEBOUNCE_W-1:0];
                REG_PERIOD:   period_us_reg   <= cfg_data[PERIOD_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            button_reg  <= button_level;
            elapsed_reg <= elapsed_us;
        end
    end

    rns_debounce u_debounce (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (step_en),
        .button_level (button_reg),
        .elapsed_us   (elapsed_reg),
        .debounce_us  (debounce_us_reg),
        .count_next   (count_next)
    );

    rns_rotator u_rotator (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (step_en),
        .elapsed_us (elapsed_reg),
        .period_us  (period_us_reg),
        .rot_next   (rot_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            led_reg   <= rot_next.led;
            mask_reg  <= off_mask(rot_next.step, count_next);
            count_reg <= count_next;
            step_reg  <= rot_next.step;
        end
    end

    assign out_valid       = out_valid_reg;
    assign led_level       = led_reg;
    assign nozzle_off_mask = mask_reg;
    assign active_nozzles  = count_reg;
    assign current_step    = step_reg;

endmodule

`default_nettype wire
